### src/tcbst_pkg.sv
`default_nettype none

package tcbst_pkg;

    localparam int COORD_WIDTH_DEF = 32;

    // tcb parameter and factor widths (Q2.14 in, 1 +/- p needs one more bit)
    localparam int PAR_W  = 16;
    localparam int FAC_W  = PAR_W + 1;
    localparam int PAIR_W = 2 * FAC_W;
    localparam int WGT_W  = 3 * FAC_W;

    // weight split for the chord products
    localparam int WLO_W = 26;
    localparam int WHI_W = WGT_W - WLO_W;

    // Q.58 sum back to Q.16 with the halving folded in
    localparam int RND_SHIFT = 43;

    localparam logic signed [FAC_W-1:0] TCB_ONE = FAC_W'(16384);

    // pipeline stages from accept to the output register
    localparam int NUM_STG = 7;

    typedef struct packed {
        logic [NUM_STG-1:0] load;
    } tcbst_pipe_t;

    typedef struct packed {
        logic signed [WGT_W-1:0] in_wdn;
        logic signed [WGT_W-1:0] in_wdp;
        logic signed [WGT_W-1:0] out_wdp;
        logic signed [WGT_W-1:0] out_wdn;
    } tcbst_wgt_t;

endpackage

`default_nettype wire

### src/tcbst_weights.sv
`default_nettype none

module tcbst_weights
    import tcbst_pkg::*;
(
    input  wire logic                    clk,
    input  wire tcbst_pipe_t             pipe,
    input  wire logic signed [PAR_W-1:0] tension,
    input  wire logic signed [PAR_W-1:0] continuity,
    input  wire logic signed [PAR_W-1:0] bias,
    output tcbst_wgt_t                   wgt
);

    logic signed [FAC_W-1:0]  omt_reg, omc_reg, opc_reg, omb_reg, opb_reg;
    logic signed [FAC_W-1:0]  omt_next, omc_next, opc_next, omb_next, opb_next;
    logic signed [FAC_W-1:0]  omt_d_reg;
    logic signed [PAIR_W-1:0] cb_out_dp_reg, cb_out_dn_reg, cb_in_dp_reg, cb_in_dn_reg;
    tcbst_wgt_t               wgt_reg;
    tcbst_wgt_t               wgt_next;

    // stage 1: the five factors 1 +/- p
    always_comb
    begin
        omt_next = TCB_ONE - {tension[PAR_W-1], tension};
        omc_next = TCB_ONE - {continuity[PAR_W-1], continuity};
        opc_next = TCB_ONE + {continuity[PAR_W-1], continuity};
        omb_next = TCB_ONE - {bias[PAR_W-1], bias};
        opb_next = TCB_ONE + {bias[PAR_W-1], bias};
    end

    always_ff @(posedge clk)
    begin
        if (pipe.load[0])
        begin
            omt_reg <= omt_next;
            omc_reg <= omc_next;
            opc_reg <= opc_next;
            omb_reg <= omb_next;
            opb_reg <= opb_next;
        end
    end

    // stage 2: continuity times bias pairs
    always_ff @(posedge clk)
    begin
        if (pipe.load[1])
        begin
            omt_d_reg     <= omt_reg;
            cb_out_dp_reg <= omc_reg * omb_reg;
            cb_out_dn_reg <= opc_reg * opb_reg;
            cb_in_dp_reg  <= opc_reg * omb_reg;
            cb_in_dn_reg  <= omc_reg * opb_reg;
        end
    end

    // stage 3: times the tension factor
    always_comb
    begin
        wgt_next.out_wdp = omt_d_reg * cb_out_dp_reg;
        wgt_next.out_wdn = omt_d_reg * cb_out_dn_reg;
        wgt_next.in_wdp  = omt_d_reg * cb_in_dp_reg;
        wgt_next.in_wdn  = omt_d_reg * cb_in_dn_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe.load[2])
        begin
            wgt_reg <= wgt_next;
        end
    end

    assign wgt = wgt_reg;

endmodule

`default_nettype wire

### src/tcbst_lane.sv
`default_nettype none

module tcbst_lane
    import tcbst_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  wire logic                          clk,
    input  wire tcbst_pipe_t                   pipe,
    input  wire logic signed [COORD_WIDTH-1:0] prev_c,
    input  wire logic signed [COORD_WIDTH-1:0] cur_c,
    input  wire logic signed [COORD_WIDTH-1:0] next_c,
    input  wire tcbst_wgt_t                    wgt,
    output logic             [COORD_WIDTH-1:0] in_tangent,
    output logic             [COORD_WIDTH-1:0] out_tangent
);

    localparam int CHW  = COORD_WIDTH + 1;
    localparam int LO_W = CHW + WLO_W + 1;
    localparam int HI_W = CHW + WHI_W;
    localparam int PW   = CHW + WGT_W;
    localparam int SW   = PW + 1;
    localparam int RW   = SW - RND_SHIFT;

    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (RND_SHIFT - 1);

    logic signed [CHW-1:0]  dn_reg [3];
    logic signed [CHW-1:0]  dp_reg [3];
    logic signed [WGT_W-1:0] w_sel [4];
    logic signed [CHW-1:0]  c_sel [4];
    logic signed [LO_W-1:0] lo_reg [4];
    logic signed [LO_W-1:0] lo_next [4];
    logic signed [HI_W-1:0] hi_reg [4];
    logic signed [HI_W-1:0] hi_next [4];
    logic signed [PW-1:0]   prod_reg [4];
    logic signed [PW-1:0]   prod_next [4];
    logic signed [SW-1:0]   in_sum_reg, out_sum_reg;

    function automatic logic [COORD_WIDTH-1:0] sat(input logic [RW-1:0] r);
        logic [RW-COORD_WIDTH:0] top;
        logic [COORD_WIDTH-1:0]  res;
        top = r[RW-1:COORD_WIDTH-1];
        if ((&top) || !(|top))
        begin
            res = r[COORD_WIDTH-1:0];
        end
        else if (r[RW-1])
        begin
            res = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
        return res;
    endfunction

    // stage 1..3: chords, then held until the weights arrive
    always_ff @(posedge clk)
    begin
        if (pipe.load[0])
        begin
            dn_reg[0] <= {cur_c[COORD_WIDTH-1], cur_c} - {prev_c[COORD_WIDTH-1], prev_c};
            dp_reg[0] <= {next_c[COORD_WIDTH-1], next_c} - {cur_c[COORD_WIDTH-1], cur_c};
        end
        if (pipe.load[1])
        begin
            dn_reg[1] <= dn_reg[0];
            dp_reg[1] <= dp_reg[0];
        end
        if (pipe.load[2])
        begin
            dn_reg[2] <= dn_reg[1];
            dp_reg[2] <= dp_reg[1];
        end
    end

    // products 0,1 make the incoming tangent, 2,3 the outgoing one
    always_comb
    begin
        w_sel[0] = wgt.in_wdn;
        w_sel[1] = wgt.in_wdp;
        w_sel[2] = wgt.out_wdp;
        w_sel[3] = wgt.out_wdn;
        c_sel[0] = dn_reg[2];
        c_sel[1] = dp_reg[2];
        c_sel[2] = dp_reg[2];
        c_sel[3] = dn_reg[2];
    end

    // stage 4: weight split into an unsigned low part and a signed high part
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            lo_next[k] = c_sel[k] * $signed({1'b0, w_sel[k][WLO_W-1:0]});
            hi_next[k] = c_sel[k] * $signed(w_sel[k][WGT_W-1:WLO_W]);
        end
    end

    // stage 5: recombine the partial products
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            prod_next[k] = (PW'(hi_reg[k]) <<< WLO_W) + PW'(lo_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe.load[3])
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
        if (pipe.load[4])
        begin
            prod_reg <= prod_next;
        end
        // stage 6: sum with the rounding offset
        if (pipe.load[5])
        begin
            in_sum_reg  <= SW'(prod_reg[0]) + SW'(prod_reg[1]) + HALF;
            out_sum_reg <= SW'(prod_reg[2]) + SW'(prod_reg[3]) + HALF;
        end
    end

    assign in_tangent  = sat(in_sum_reg[SW-1:RND_SHIFT]);
    assign out_tangent = sat(out_sum_reg[SW-1:RND_SHIFT]);

endmodule

`default_nettype wire

### src/tcb_spline_tangents.sv
// throughput: one request per cycle while m_axis_tready is high, set by the
//   seven-stage pipeline of weight and chord multipliers; a stalled stage
//   holds only the stages behind it
// reset: rst_n clears the stage valid flags only, the datapath is not reset
`default_nettype none

module tcb_spline_tangents
    import tcbst_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // prev_x, prev_y, prev_z, cur_x, cur_y, cur_z, next_x, next_y, next_z,
    // tension, continuity, bias
    input  wire logic [((9 * COORD_WIDTH + 3 * PAR_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // in_tangent_x, in_tangent_y, in_tangent_z,
    // out_tangent_x, out_tangent_y, out_tangent_z
    output logic [((6 * COORD_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int CW     = COORD_WIDTH;
    localparam int OUT_W  = 6 * COORD_WIDTH;
    localparam int OUT_DW = ((6 * COORD_WIDTH + 7) / 8) * 8;

    logic [NUM_STG-1:0] valid_reg;
    logic [NUM_STG-1:0] valid_next;
    logic [NUM_STG:0]   ready;
    tcbst_pipe_t        pipe;
    tcbst_wgt_t         wgt;
    logic [CW-1:0]      in_tan [3];
    logic [CW-1:0]      out_tan [3];
    logic [OUT_W-1:0]   data_reg;
    logic [OUT_W-1:0]   data_next;

    // a stage loads when it is empty or its successor takes its contents
    always_comb
    begin
        ready[NUM_STG] = m_axis_tready;
        for (int k = NUM_STG - 1; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
        pipe.load = ready[NUM_STG-1:0];
        valid_next = valid_reg;
        if (ready[0])
        begin
            valid_next[0] = s_axis_tvalid;
        end
        for (int k = 1; k < NUM_STG; k++)
        begin
            if (ready[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    tcbst_weights u_weights
    (
        .clk        (clk),
        .pipe       (pipe),
        .tension    (s_axis_tdata[9 * CW +: PAR_W]),
        .continuity (s_axis_tdata[9 * CW + PAR_W +: PAR_W]),
        .bias       (s_axis_tdata[9 * CW + 2 * PAR_W +: PAR_W]),
        .wgt        (wgt)
    );

    for (genvar a = 0; a < 3; a++)
    begin : g_lane
        tcbst_lane #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_lane
        (
            .clk         (clk),
            .pipe        (pipe),
            .prev_c      (s_axis_tdata[a * CW +: CW]),
            .cur_c       (s_axis_tdata[(3 + a) * CW +: CW]),
            .next_c      (s_axis_tdata[(6 + a) * CW +: CW]),
            .wgt         (wgt),
            .in_tangent  (in_tan[a]),
            .out_tangent (out_tan[a])
        );
    end

    // merge the three lanes into one result word
    always_comb
    begin
        data_next = '0;
        for (int a = 0; a < 3; a++)
        begin
            data_next[a * CW +: CW]       = in_tan[a];
            data_next[(3 + a) * CW +: CW] = out_tan[a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe.load[NUM_STG-1])
        begin
            data_reg <= data_next;
        end
    end

    assign s_axis_tready = ready[0];
    assign m_axis_tvalid = valid_reg[NUM_STG-1];
    assign m_axis_tdata  = OUT_DW'(data_reg);

endmodule

`default_nettype wire
